// ===== rtl/word15_accumulator_alu_assert.svh =====
// Assertion helpers used by the top-level RTL file.
// Both expect clk and rst_n in scope.
`ifndef WORD15_ACCUMULATOR_ALU_ASSERT_SVH
`define WORD15_ACCUMULATOR_ALU_ASSERT_SVH

// Same-cycle implication.
`define W15_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define W15_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/w15alu_pkg.sv =====
package w15alu_pkg;

  localparam int WORD_W     = 15;
  localparam int MAG_W      = 14;
  localparam int CELL_W     = 7;
  localparam int MODE_W     = 3;
  localparam int DEST_W     = 2;
  localparam int CELL_COUNT = 128;
  localparam int CELL_CMP_W = 13;
  // Quotient bits resolved per divider stage
  localparam int DIV_STEPS  = 3;
  localparam int DIV_STAGES = WORD_W / DIV_STEPS;

  localparam logic [WORD_W-1:0] SIGN_BIT = 15'h4000;

  typedef enum logic [MODE_W-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_DIV = 3'd2,
    OP_MUL = 3'd3,
    OP_NOT = 3'd4,
    OP_AND = 3'd5
  } alu_op_t;

  typedef enum logic [DEST_W-1:0] {
    DEST_CALLER = 2'd0,
    DEST_ACC    = 2'd1,
    DEST_MEM    = 2'd2
  } dest_t;

  // Payload carried down the divider pipeline
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [WORD_W-1:0] acc;
    logic [WORD_W-1:0] mem;
    logic [CELL_W-1:0] cell_idx;
    logic              bad;
    logic [MAG_W-1:0]  prod_lo;
    logic [WORD_W-1:0] rem;
    logic [WORD_W-1:0] dvd;
    logic [WORD_W-1:0] quo;
  } div_pipe_t;

endpackage

// ===== rtl/w15alu_if.sv =====
interface w15alu_in_if import w15alu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [WORD_W-1:0] acc_word;
  logic [WORD_W-1:0] mem_word;
  logic [CELL_W-1:0] cell_index;
  logic              mem_fault_in;

  modport source (output valid, mode, acc_word, mem_word, cell_index, mem_fault_in,
                  input ready);
  modport sink   (input valid, mode, acc_word, mem_word, cell_index, mem_fault_in,
                  output ready);
endinterface

interface w15alu_out_if import w15alu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] result_word;
  logic [DEST_W-1:0] destination;
  logic [CELL_W-1:0] write_cell;
  logic              fault;
  logic              divide_by_zero;

  modport source (output valid, result_word, destination, write_cell, fault,
                  divide_by_zero, input ready);
  modport sink   (input valid, result_word, destination, write_cell, fault,
                  divide_by_zero, output ready);
endinterface

// ===== rtl/w15alu_div_stage.sv =====
module w15alu_div_stage import w15alu_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      en,
  input  logic      in_valid,
  input  div_pipe_t in_data,
  output logic      out_valid,
  output div_pipe_t out_data
);

  logic      valid_r;
  div_pipe_t data_r;
  div_pipe_t data_nxt;

  // Restoring division: DIV_STEPS quotient bits per stage, MSB first
  always_comb begin
    logic [WORD_W:0] trial;
    data_nxt = in_data;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {data_nxt.rem, data_nxt.dvd[WORD_W-1]};
      data_nxt.dvd = {data_nxt.dvd[WORD_W-2:0], 1'b0};
      if (trial >= {1'b0, data_nxt.mem}) begin
        data_nxt.rem = WORD_W'(trial - {1'b0, data_nxt.mem});
        data_nxt.quo = {data_nxt.quo[WORD_W-2:0], 1'b1};
      end else begin
        data_nxt.rem = trial[WORD_W-1:0];
        data_nxt.quo = {data_nxt.quo[WORD_W-2:0], 1'b0};
      end
    end
  end

  // Valid bit is reset, payload is not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/word15_accumulator_alu.sv =====
// A beat passes the input register, 5 divider stages and the output register.
// Throughput: one beat per cycle; the whole pipeline holds while out_bus stalls.
// Depth is set by the 15-bit quotient, resolved 3 bits per stage over 5 stages.
// Reset (rst_n low, synchronous) clears every stage valid bit; payload is not reset.
module word15_accumulator_alu import w15alu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  w15alu_in_if.sink   in_bus,
  w15alu_out_if.source out_bus
);

  `include "word15_accumulator_alu_assert.svh"

  logic                  en;
  logic [DIV_STAGES:0]   stg_valid;
  div_pipe_t             stg_data [0:DIV_STAGES];

  logic                  in_valid_r;
  div_pipe_t             in_data_r;
  div_pipe_t             in_data_nxt;
  logic [2*WORD_W-1:0]   prod;

  logic                  out_valid_r;
  logic [WORD_W-1:0]     res_r, res_nxt;
  dest_t                 dest_r, dest_nxt;
  logic [CELL_W-1:0]     wcell_r, wcell_nxt;
  logic                  flt_r, flt_nxt;
  logic                  dz_r, dz_nxt;

  // Global advance: move when the output slot is free or being drained
  assign en           = !out_valid_r || out_bus.ready;
  assign in_bus.ready = en;

  // Input stage: range check, multiply, divider seed
  assign prod = (2*WORD_W)'(in_bus.acc_word) * (2*WORD_W)'(in_bus.mem_word);

  always_comb begin
    in_data_nxt          = '0;
    in_data_nxt.mode     = in_bus.mode;
    in_data_nxt.acc      = in_bus.acc_word;
    in_data_nxt.mem      = in_bus.mem_word;
    in_data_nxt.cell_idx = in_bus.cell_index;
    in_data_nxt.bad      = in_bus.mem_fault_in ||
                           (CELL_CMP_W'(in_bus.cell_index) >= CELL_CMP_W'(CELL_COUNT));
    in_data_nxt.prod_lo  = prod[MAG_W-1:0];
    in_data_nxt.dvd      = in_bus.acc_word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (en) begin
      in_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_data_r <= in_data_nxt;
    end
  end

  assign stg_valid[0] = in_valid_r;
  assign stg_data[0]  = in_data_r;

  // Divider stages
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    w15alu_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (stg_valid[g]),
      .in_data   (stg_data[g]),
      .out_valid (stg_valid[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  // Result formation from the last divider stage
  always_comb begin
    div_pipe_t d;
    logic      sd;
    d         = stg_data[DIV_STAGES];
    sd        = d.acc[WORD_W-1] ^ d.mem[WORD_W-1];
    res_nxt   = '0;
    dest_nxt  = DEST_CALLER;
    wcell_nxt = '0;
    flt_nxt   = 1'b0;
    dz_nxt    = 1'b0;
    if (d.mode <= OP_AND && d.bad) begin
      flt_nxt = 1'b1;
    end else begin
      case (alu_op_t'(d.mode))
        OP_ADD: res_nxt = d.acc + d.mem;
        OP_SUB: res_nxt = d.acc - d.mem;
        OP_DIV: begin
          if (d.mem == '0) begin
            dz_nxt = 1'b1;
          end else begin
            res_nxt = {sd, d.quo[MAG_W-1:0]};
          end
        end
        OP_MUL: begin
          if (sd) begin
            res_nxt = ({1'b0, ~d.prod_lo} + WORD_W'(1)) | SIGN_BIT;
          end else begin
            res_nxt = {1'b0, d.prod_lo};
          end
        end
        OP_NOT: begin
          res_nxt   = ~d.acc;
          dest_nxt  = DEST_MEM;
          wcell_nxt = d.cell_idx;
        end
        OP_AND: begin
          res_nxt  = d.acc & d.mem;
          dest_nxt = DEST_ACC;
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r   <= res_nxt;
      dest_r  <= dest_nxt;
      wcell_r <= wcell_nxt;
      flt_r   <= flt_nxt;
      dz_r    <= dz_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.result_word    = res_r;
  assign out_bus.destination    = dest_r;
  assign out_bus.write_cell     = wcell_r;
  assign out_bus.fault          = flt_r;
  assign out_bus.divide_by_zero = dz_r;

  // Checks
  `W15_ASSERT_NEXT(a_stall_freezes, !en, $stable(stg_valid) && $stable(out_valid_r), "pipeline moved during stall")
  `W15_ASSERT_NOW(a_fault_clean, out_valid_r && flt_r, res_r == '0 && dest_r == DEST_CALLER && !dz_r, "fault beat not clean")
  `W15_ASSERT_NOW(a_dz_clean, out_valid_r && dz_r, res_r == '0 && !flt_r && dest_r == DEST_CALLER, "divide-by-zero beat not clean")
  `W15_ASSERT_NOW(a_wcell_unused, out_valid_r && dest_r != DEST_MEM, wcell_r == '0, "write cell set without memory destination")

endmodule

// ===== tb/word15_accumulator_alu_test.sv =====
module word15_accumulator_alu_test;
  import w15alu_pkg::*;

  // Modes with no operation behind them
  localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

  localparam int PIPE_LATENCY = 6;
  localparam int HOLD_OFF_LEN = 60;
  localparam int IDLE_LIMIT   = 1000;
  localparam int PRINT_CAP    = 40;

  typedef struct {
    logic [WORD_W-1:0] word;
    dest_t             dest;
    logic [CELL_W-1:0] wcell;
    logic              fault;
    logic              div_zero;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst_n;

  w15alu_in_if  in_if ();
  w15alu_out_if out_if ();

  word15_accumulator_alu u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if)
  );

  alu_result_t pending_results[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;
  bit hold_off_req  = 1'b0;
  int quiet_cycles  = 0;
  int mismatches    = 0;
  int beats_sent    = 0;
  int results_seen  = 0;
  int faults_sent   = 0;
  int zero_divs     = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected result of one ALU operation
  function automatic alu_result_t alu_predict(input logic [MODE_W-1:0] mode,
                                              input logic [WORD_W-1:0] acc,
                                              input logic [WORD_W-1:0] mem,
                                              input logic [CELL_W-1:0] cell_idx,
                                              input logic              fault_in);
    alu_result_t         r;
    logic [2*WORD_W-1:0] prod;
    logic [WORD_W-1:0]   quo;
    logic [MAG_W-1:0]    low;
    logic                differ;
    r.word     = '0;
    r.dest     = DEST_CALLER;
    r.wcell    = '0;
    r.fault    = 1'b0;
    r.div_zero = 1'b0;
    differ = acc[MAG_W] ^ mem[MAG_W];
    // An access fault aborts every real operation; unused modes touch nothing
    if (int'(mode) <= int'(OP_AND) && (fault_in || int'(cell_idx) >= CELL_COUNT)) begin
      r.fault = 1'b1;
    end else begin
      case (mode)
        OP_ADD: r.word = acc + mem;
        OP_SUB: r.word = acc - mem;
        OP_DIV: begin
          if (mem == '0) begin
            r.div_zero = 1'b1;
          end else begin
            quo    = acc / mem;
            r.word = {differ, quo[MAG_W-1:0]};
          end
        end
        OP_MUL: begin
          prod = acc * mem;
          low  = prod[MAG_W-1:0];
          // negate within 14 bits; a zero product leaves only the sign bit
          if (differ) r.word = {1'b1, MAG_W'(~low + 1'b1)};
          else        r.word = {1'b0, low};
        end
        OP_NOT: begin
          r.word  = ~acc;
          r.dest  = DEST_MEM;
          r.wcell = cell_idx;
        end
        OP_AND: begin
          r.word = acc & mem;
          r.dest = DEST_ACC;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH @%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Result check first, then queue the prediction for an accepted operand beat
  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n === 1'b1) begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing pending", out_if.result_word, 0);
        end else begin
          want = pending_results.pop_front();
          if (out_if.result_word !== want.word)
            report_mismatch("result_word", out_if.result_word, want.word);
          if (out_if.destination !== want.dest)
            report_mismatch("destination", out_if.destination, want.dest);
          if (out_if.write_cell !== want.wcell)
            report_mismatch("write_cell", out_if.write_cell, want.wcell);
          if (out_if.fault !== want.fault)
            report_mismatch("fault", out_if.fault, want.fault);
          if (out_if.divide_by_zero !== want.div_zero)
            report_mismatch("divide_by_zero", out_if.divide_by_zero, want.div_zero);
        end
      end
      if (in_if.valid && in_if.ready) begin
        want = alu_predict(in_if.mode, in_if.acc_word, in_if.mem_word,
                           in_if.cell_index, in_if.mem_fault_in);
        pending_results.push_back(want);
        beats_sent++;
        if (want.fault) faults_sent++;
        if (want.div_zero) zero_divs++;
      end
      // Watchdog: cycles with no beat on either side
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  initial begin
    wait (quiet_cycles >= IDLE_LIMIT);
    $display("Timeout: no beat for %0d cycles, %0d results pending",
             IDLE_LIMIT, pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

  // Result side: random back-pressure plus an on-demand long hold-off
  always @(negedge clk) begin
    if (rst_n !== 1'b1) begin
      out_if.ready <= 1'b0;
    end else begin
      if (hold_off_left == 0 && hold_off_req) hold_off_left = HOLD_OFF_LEN;
      if (hold_off_left > 0) begin
        hold_off_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one operand beat; returns at the falling edge after acceptance
  task automatic send_operand(input logic [MODE_W-1:0] mode,
                              input logic [WORD_W-1:0] acc,
                              input logic [WORD_W-1:0] mem,
                              input logic [CELL_W-1:0] cell_idx,
                              input logic              fault_in);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.mode         <= mode;
    in_if.acc_word     <= acc;
    in_if.mem_word     <= mem;
    in_if.cell_index   <= cell_idx;
    in_if.mem_fault_in <= fault_in;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    @(negedge clk);
  endtask

  task automatic wait_for_results;
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Operand biased toward the sign and wrap boundaries
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(9))
      0: return '0;
      1: return 15'h7FFF;
      2: return SIGN_BIT;
      3: return 15'h3FFF;
      4: return 15'd1;
      default: return WORD_W'($urandom);
    endcase
  endfunction

  task automatic test_directed;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_operand(OP_ADD, 15'h7FFF, 15'h7FFF, 7'd0, 1'b0);
    send_operand(OP_ADD, 15'h0000, 15'h0000, 7'd127, 1'b0);
    send_operand(OP_SUB, 15'h0000, 15'h0001, 7'd3, 1'b0);
    send_operand(OP_SUB, 15'h7FFF, 15'h7FFF, 7'd64, 1'b0);
    send_operand(OP_DIV, 15'h7FFF, 15'h0001, 7'd1, 1'b0);
    // zero divisor, including zero over zero
    send_operand(OP_DIV, 15'h0005, 15'h0000, 7'd9, 1'b0);
    send_operand(OP_DIV, 15'h0000, 15'h0000, 7'd127, 1'b0);
    send_operand(OP_DIV, SIGN_BIT, SIGN_BIT, 7'd2, 1'b0);
    // zero product with differing signs carries into the sign bit
    send_operand(OP_MUL, SIGN_BIT, 15'h0000, 7'd5, 1'b0);
    send_operand(OP_MUL, 15'h7FFF, 15'h7FFF, 7'd6, 1'b0);
    send_operand(OP_MUL, 15'h0003, 15'h4001, 7'd7, 1'b0);
    // NOT writes back to the addressed cell
    send_operand(OP_NOT, 15'h0000, 15'h7FFF, 7'd127, 1'b0);
    send_operand(OP_NOT, 15'h7FFF, 15'h0000, 7'd0, 1'b0);
    send_operand(OP_NOT, 15'h2AAA, 15'h5555, 7'h55, 1'b0);
    send_operand(OP_AND, 15'h7FFF, 15'h5555, 7'h2A, 1'b0);
    send_operand(OP_AND, 15'h0000, 15'h7FFF, 7'd127, 1'b0);
    // memory fault aborts every real operation
    for (int m = int'(OP_ADD); m <= int'(OP_AND); m++)
      send_operand(MODE_W'(m), 15'h7FFF, 15'h0000, 7'h2A, 1'b1);
    // unused modes do nothing, even with a fault raised
    send_operand(MODE_UNUSED_LO, 15'h7FFF, 15'h7FFF, 7'd127, 1'b0);
    send_operand(MODE_UNUSED_HI, 15'h1234, 15'h4321, 7'd17, 1'b1);
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int beats, input int send_pct, input int recv_pct);
    logic [MODE_W-1:0] mode;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (beats) begin
      if ($urandom_range(9) == 0)
        mode = MODE_W'($urandom_range(int'(MODE_UNUSED_HI), int'(MODE_UNUSED_LO)));
      else
        mode = MODE_W'($urandom_range(int'(OP_AND)));
      send_operand(mode, pick_word(), pick_word(), CELL_W'($urandom_range(127)),
                   ($urandom_range(11) == 0));
    end
    wait_for_results();
  endtask

  // Long output stall fills the pipeline while operands keep coming
  task automatic test_output_stall;
    send_idle_pct = 0;
    recv_idle_pct = 20;
    hold_off_req  = 1'b1;
    while (hold_off_left == 0) @(posedge clk);
    hold_off_req = 1'b0;
    @(negedge clk);
    repeat (30)
      send_operand(MODE_W'($urandom_range(int'(OP_AND))), pick_word(), pick_word(),
                   CELL_W'($urandom_range(127)), 1'b0);
    wait_for_results();
  endtask

  initial begin
    rst_n              = 1'b0;
    in_if.valid        = 1'b0;
    in_if.mode         = '0;
    in_if.acc_word     = '0;
    in_if.mem_word     = '0;
    in_if.cell_index   = '0;
    in_if.mem_fault_in = 1'b0;
    out_if.ready       = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_traffic(370, 27, 62);
    test_random_traffic(370, 62, 27);
    test_random_traffic(370, 0, 0);
    test_output_stall();

    // let anything stray reach the output
    repeat (PIPE_LATENCY + 5) @(negedge clk);
    $display("Checked %0d results against %0d operand beats: all six operations,",
             results_seen, beats_sent);
    $display("unused modes, %0d faulted accesses, %0d zero divisors, mixed idling, long stall.",
             faults_sent, zero_divs);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
